// File: rtl/core/epdu_pkg.sv
// Shared types, opcodes and decode helpers for the EGA dither decoder.
`default_nettype none

package epdu_pkg;

    // Histogram geometry.
    localparam int unsigned HistDepth = 256;
    localparam int unsigned HistAw    = $clog2(HistDepth);
    localparam int unsigned CountW    = 16;
    localparam int unsigned ColorW    = 8;

    // Opcodes carried by an input word; the fourth code is unused.
    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    // Control and payload that leave decode for the histogram stage.
    typedef struct packed {
        logic                 inc;       // bump the counter at addr
        logic                 rd;        // report the counter at addr
        logic                 clr;       // flash-clear the histogram
        logic                 wr_pix;    // pixel was rewritten
        logic [ColorW-1:0]    vis;       // new visual byte
        logic [ColorW-1:0]    disp;      // byte for the display
        logic [HistAw-1:0]    addr;      // histogram entry touched
    } t_dec;

    // Undo the dither encoding: low nibble kept, high nibble XORed with it.
    function automatic logic [ColorW-1:0] undither_byte(input logic [ColorW-1:0] src);
        undither_byte = src ^ {src[3:0], 4'h0};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/epdu_in_if.sv
// Input channel interface: one pixel or histogram command word.
`default_nettype none

interface epdu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  source_color;
    logic [9:0]  column;
    logic [8:0]  row;
    logic [7:0]  entry_index;

    modport source (
        output valid, opcode, source_color, column, row, entry_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, source_color, column, row, entry_index,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/epdu_out_if.sv
// Output channel interface: one result word.
`default_nettype none

interface epdu_out_if;
    logic        valid;
    logic        ready;
    logic        write_pixel;
    logic [7:0]  visual_color;
    logic [7:0]  display_color;
    logic [15:0] entry_count;

    modport source (
        output valid, write_pixel, visual_color, display_color, entry_count,
        input  ready
    );
    modport sink (
        input  valid, write_pixel, visual_color, display_color, entry_count,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/epdu_decode.sv
// Pixel decode: undithers the byte and works out colors and histogram action.
`default_nettype none

module epdu_decode (
    input  wire logic [1:0]              i_opcode,
    input  wire logic [7:0]              i_source_color,
    input  wire logic                    i_parity,
    input  wire logic [7:0]              i_entry_index,
    input  wire logic                    i_undither,
    output epdu_pkg::t_dec               o_dec
);

    logic       is_pixel;
    logic       hi_set;
    logic [7:0] dec_byte;
    logic [7:0] nib_sel;
    logic [7:0] undither_disp;

    // The decoded byte and the nibble picked by checkerboard parity.
    always_comb begin
        is_pixel      = (i_opcode == epdu_pkg::OP_PIXEL);
        hi_set        = |i_source_color[7:4];
        dec_byte      = epdu_pkg::undither_byte(i_source_color);
        nib_sel       = i_parity ? {4'h0, dec_byte[7:4]} : {4'h0, dec_byte[3:0]};
        undither_disp = (|dec_byte[7:4]) ? dec_byte : {dec_byte[3:0], 4'h0};
    end

    // Result fields and histogram action for the word.
    always_comb begin
        o_dec        = '0;
        o_dec.clr    = (i_opcode == epdu_pkg::OP_CLEAR);
        o_dec.rd     = (i_opcode == epdu_pkg::OP_READ) && i_undither;
        o_dec.addr   = (i_opcode == epdu_pkg::OP_READ) ? i_entry_index : dec_byte;
        if (is_pixel) begin
            if (hi_set) begin
                o_dec.wr_pix = 1'b1;
                o_dec.inc    = i_undither;
                o_dec.vis    = nib_sel;
                o_dec.disp   = i_undither ? undither_disp : nib_sel;
            end else begin
                o_dec.vis    = i_source_color;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/epdu_hist_ram.sv
// Histogram counter memory: one write port, one registered read port.
`default_nettype none

module epdu_hist_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_rd_en,
    input  wire logic [epdu_pkg::HistAw-1:0]   i_rd_addr,
    output logic      [epdu_pkg::CountW-1:0]   o_rd_data,
    input  wire logic                          i_wr_en,
    input  wire logic [epdu_pkg::HistAw-1:0]   i_wr_addr,
    input  wire logic [epdu_pkg::CountW-1:0]   i_wr_data
);

    logic [epdu_pkg::CountW-1:0] r_mem [epdu_pkg::HistDepth];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds while not enabled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ega_pixel_dither_undither.sv
// An accepted word waits in the stage register while its counter is read, then
// moves into the result register once that register is free or being drained.
// Throughput: one word per cycle unless stalled; histogram read, increment
// and write-back overlap from word to word through a bypass of the last write.
// Reset (synchronous, active low) empties the pipeline, sets undither mode and
// marks every histogram entry invalid at once, so all counters read as zero.
`default_nettype none

module ega_pixel_dither_undither (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    epdu_in_if.sink         i_in,
    epdu_out_if.source      o_out,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data
);

    logic                              r_undither;
    epdu_pkg::t_dec                    dec;
    epdu_pkg::t_dec                    r_s1;
    logic                              r_s1_vld;
    logic                              s1_adv;
    logic                              in_acc;
    logic [epdu_pkg::HistDepth-1:0]    r_ent_vld;
    logic [epdu_pkg::CountW-1:0]       ram_rdata;
    logic                              r_fwd;
    logic [epdu_pkg::CountW-1:0]       r_fwd_data;
    logic [epdu_pkg::CountW-1:0]       cur_count;
    logic [epdu_pkg::CountW-1:0]       inc_count;
    logic                              hist_we;
    logic                              r_out_vld;
    logic                              r_out_wr;
    logic [7:0]                        r_out_vis;
    logic [7:0]                        r_out_disp;
    logic [epdu_pkg::CountW-1:0]       r_out_cnt;

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_undither <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_undither <= i_cfg_wr_data;
        end
    end

    // Handshake: the histogram stage moves when the output register frees up.
    assign s1_adv     = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    epdu_decode u_decode (
        .i_opcode       (i_in.opcode),
        .i_source_color (i_in.source_color),
        .i_parity       (i_in.column[0] ^ i_in.row[0]),
        .i_entry_index  (i_in.entry_index),
        .i_undither     (r_undither),
        .o_dec          (dec)
    );

    epdu_hist_ram u_hist_ram (
        .i_clk      (i_clk),
        .i_rd_en    (in_acc),
        .i_rd_addr  (dec.addr),
        .o_rd_data  (ram_rdata),
        .i_wr_en    (hist_we),
        .i_wr_addr  (r_s1.addr),
        .i_wr_data  (inc_count)
    );

    // Stage register holding the decoded word while its counter is read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= dec;
        end
    end

    // Current count: the bypassed last write wins, an invalid entry reads zero.
    always_comb begin
        if (r_fwd) begin
            cur_count = r_fwd_data;
        end else if (r_ent_vld[r_s1.addr]) begin
            cur_count = ram_rdata;
        end else begin
            cur_count = '0;
        end
        inc_count = cur_count + epdu_pkg::CountW'(1);
        hist_we   = s1_adv && r_s1.inc;
    end

    // Bypass: the memory read issued on the same edge as a write misses it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_acc) begin
            r_fwd <= hist_we && (r_s1.addr == dec.addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_data <= inc_count;
        end
    end

    // Entry valid bits: a clear drops them all, a write marks its entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (s1_adv && r_s1.clr) begin
            r_ent_vld <= '0;
        end else if (hist_we) begin
            r_ent_vld[r_s1.addr] <= 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_wr   <= r_s1.wr_pix;
            r_out_vis  <= r_s1.vis;
            r_out_disp <= r_s1.disp;
            r_out_cnt  <= r_s1.rd ? cur_count : '0;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.write_pixel   = r_out_wr;
    assign o_out.visual_color  = r_out_vis;
    assign o_out.display_color = r_out_disp;
    assign o_out.entry_count   = r_out_cnt;

endmodule

`default_nettype wire

// File: rtl/core/epdu_checker.sv
// Port-level checks for the dither decoder, bound to the top level.
`default_nettype none

module epdu_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_write_pixel,
    input  wire logic [7:0]  i_visual_color,
    input  wire logic [7:0]  i_display_color,
    input  wire logic [15:0] i_entry_count
);

    // Reset empties the result register by the next cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // A rewritten pixel carries only one nibble as its visual color and no count.
    a_vis_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_write_pixel |-> i_visual_color[7:4] == 4'h0
                                         && i_entry_count == 16'h0)
        else $error("rewritten pixel with wide visual color or a count");

    // Words that rewrite no pixel put nothing on the display.
    a_no_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_write_pixel |-> i_display_color == 8'h0)
        else $error("display color without a rewritten pixel");

endmodule

bind ega_pixel_dither_undither epdu_checker u_epdu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_write_pixel   (o_out.write_pixel),
    .i_visual_color  (o_out.visual_color),
    .i_display_color (o_out.display_color),
    .i_entry_count   (o_out.entry_count)
);

`default_nettype wire

// File: bench/tb_ega_pixel_dither_undither.sv
// Self-checking testbench for the EGA dither decoder with its undither histogram.
`timescale 1ns / 100ps

module tb_ega_pixel_dither_undither;

    // The fourth opcode has no meaning and must leave everything untouched.
    localparam epdu_pkg::t_opcode OP_UNUSED = epdu_pkg::t_opcode'(2'd3);
    localparam int unsigned CycleLimit = 400000;
    // Number of back-to-back hits on one counter.
    localparam int unsigned HitRun = 40;

    typedef struct packed {
        epdu_pkg::t_opcode                opcode;
        logic [epdu_pkg::ColorW-1:0]      source_color;
        logic [9:0]                       column;
        logic [8:0]                       row;
        logic [epdu_pkg::HistAw-1:0]      entry_index;
    } t_word;

    typedef struct packed {
        logic                             write_pixel;
        logic [epdu_pkg::ColorW-1:0]      visual_color;
        logic [epdu_pkg::ColorW-1:0]      display_color;
        logic [epdu_pkg::CountW-1:0]      entry_count;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    epdu_in_if  in_bus ();
    epdu_out_if out_bus ();

    ega_pixel_dither_undither u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_bus),
        .o_out         (out_bus),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Mirror of the block's state and mode.
    logic [epdu_pkg::CountW-1:0] hist_count [epdu_pkg::HistDepth];
    logic                        undither_mode;

    t_word   pending_words [$];
    t_result awaited_results [$];
    logic    word_held;
    int      send_gap;
    int      recv_stall;
    int      stall_pct;
    int      err_count;
    int      cycle_count;
    logic [epdu_pkg::ColorW-1:0] hot_color [6];

    // Clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predicts the result of one accepted word and updates the histogram mirror.
    task automatic decode_pixel_word(input t_word w, output t_result r);
        logic [epdu_pkg::ColorW-1:0] dec;
        logic                        par;
        int                          i;
        r   = '0;
        par = w.column[0] ^ w.row[0];
        dec = w.source_color ^ {w.source_color[3:0], 4'h0};
        case (w.opcode)
            epdu_pkg::OP_PIXEL: begin
                if (w.source_color[7:4] != 4'h0) begin
                    r.write_pixel  = 1'b1;
                    r.visual_color = par ? {4'h0, dec[7:4]} : {4'h0, dec[3:0]};
                    if (undither_mode) begin
                        hist_count[dec] = hist_count[dec] + 1'b1;
                        r.display_color = (dec[7:4] != 4'h0) ? dec : {dec[3:0], 4'h0};
                    end else begin
                        r.display_color = r.visual_color;
                    end
                end else begin
                    // Pixel not written: the stored byte comes back unchanged.
                    r.visual_color = w.source_color;
                end
            end
            epdu_pkg::OP_CLEAR: begin
                for (i = 0; i < epdu_pkg::HistDepth; i++) hist_count[i] = '0;
            end
            epdu_pkg::OP_READ: begin
                if (undither_mode) r.entry_count = hist_count[w.entry_index];
            end
            default: ;
        endcase
    endtask

    task automatic push_word(input epdu_pkg::t_opcode op,
                             input logic [epdu_pkg::ColorW-1:0] src,
                             input logic [9:0] col, input logic [8:0] rw,
                             input logic [epdu_pkg::HistAw-1:0] idx);
        t_word w;
        w.opcode       = op;
        w.source_color = src;
        w.column       = col;
        w.row          = rw;
        w.entry_index  = idx;
        pending_words.push_back(w);
    endtask

    // Random word: mostly pixels, often from a small pool of colors so that
    // histogram reads find nonzero counts.
    task automatic push_random_word();
        epdu_pkg::t_opcode           op;
        logic [epdu_pkg::ColorW-1:0] src;
        logic [epdu_pkg::ColorW-1:0] hot;
        logic [epdu_pkg::HistAw-1:0] idx;
        int                          pick;
        pick = $urandom_range(99);
        if (pick < 78)      op = epdu_pkg::OP_PIXEL;
        else if (pick < 92) op = epdu_pkg::OP_READ;
        else if (pick < 95) op = epdu_pkg::OP_CLEAR;
        else                op = OP_UNUSED;
        hot = hot_color[$urandom_range(5)];
        src = ($urandom_range(1) == 1) ? hot : epdu_pkg::ColorW'($urandom_range(255));
        if ($urandom_range(1) == 1)
            idx = hot ^ {hot[3:0], 4'h0};
        else
            idx = epdu_pkg::HistAw'($urandom_range(255));
        push_word(op, src, 10'($urandom_range(1023)), 9'($urandom_range(511)), idx);
    endtask

    task automatic refill_hot_colors();
        int i;
        for (i = 0; i < 6; i++) hot_color[i] = epdu_pkg::ColorW'($urandom_range(16, 255));
    endtask

    // Waits until every word has been sent and every result has come back.
    task automatic wait_drained();
        while (pending_words.size() != 0 || word_held || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Sender: one word at a time, with random gaps between words while stall_pct is set.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!word_held) begin
            if (send_gap > 0) begin
                send_gap     = send_gap - 1;
                in_bus.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
                    send_gap     = $urandom_range(1, 8) - 1;
                    in_bus.valid <= 1'b0;
                end else begin
                    in_bus.opcode       <= pending_words[0].opcode;
                    in_bus.source_color <= pending_words[0].source_color;
                    in_bus.column       <= pending_words[0].column;
                    in_bus.row          <= pending_words[0].row;
                    in_bus.entry_index  <= pending_words[0].entry_index;
                    in_bus.valid        <= 1'b1;
                    void'(pending_words.pop_front());
                    word_held = 1'b1;
                end
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: ready drops in random bursts while stall_pct is set.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall    = recv_stall - 1;
            out_bus.ready <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            recv_stall    = $urandom_range(1, 8) - 1;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // Monitor: predicts on every accepted word, checks every accepted result.
    always @(posedge i_clk) begin
        t_word   w;
        t_result got;
        t_result exp_r;
        if (i_rst_n) begin
            if (i_cfg_wr_en) undither_mode = i_cfg_wr_data;
            if (in_bus.valid && in_bus.ready) begin
                w.opcode       = epdu_pkg::t_opcode'(in_bus.opcode);
                w.source_color = in_bus.source_color;
                w.column       = in_bus.column;
                w.row          = in_bus.row;
                w.entry_index  = in_bus.entry_index;
                decode_pixel_word(w, exp_r);
                awaited_results.push_back(exp_r);
                word_held = 1'b0;
            end
            if (out_bus.valid && out_bus.ready) begin
                got.write_pixel   = out_bus.write_pixel;
                got.visual_color  = out_bus.visual_color;
                got.display_color = out_bus.display_color;
                got.entry_count   = out_bus.entry_count;
                if (awaited_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"ERROR: result with nothing awaited: ",
                                  "wr=%0d vis=%02h disp=%02h cnt=%0d"},
                                 got.write_pixel, got.visual_color, got.display_color,
                                 got.entry_count);
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (got.write_pixel !== exp_r.write_pixel
                            || got.visual_color !== exp_r.visual_color
                            || got.display_color !== exp_r.display_color
                            || got.entry_count !== exp_r.entry_count) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"ERROR: exp wr=%0d vis=%02h disp=%02h cnt=%0d, ",
                                      "got wr=%0d vis=%02h disp=%02h cnt=%0d"},
                                     exp_r.write_pixel, exp_r.visual_color,
                                     exp_r.display_color, exp_r.entry_count,
                                     got.write_pixel, got.visual_color,
                                     got.display_color, got.entry_count);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("ega_pixel_dither_undither test failed");
            $finish;
        end
    end

    // Stimulus and final verdict.
    initial begin
        int i;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_wr_data       = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.opcode       = epdu_pkg::OP_PIXEL;
        in_bus.source_color = '0;
        in_bus.column       = '0;
        in_bus.row          = '0;
        in_bus.entry_index  = '0;
        out_bus.ready       = 1'b0;
        word_held           = 1'b0;
        send_gap            = 0;
        recv_stall          = 0;
        stall_pct           = 0;
        err_count           = 0;
        cycle_count         = 0;
        undither_mode       = 1'b1;
        for (i = 0; i < epdu_pkg::HistDepth; i++) hist_count[i] = '0;
        refill_hot_colors();

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(1'b1);

        // Directed words in undither mode: nibble extremes, checkerboard phases,
        // unwritten pixels, reads, clear and the unused opcode.
        push_word(epdu_pkg::OP_PIXEL, 8'h00, 10'd0, 9'd0, 8'h00);
        push_word(epdu_pkg::OP_PIXEL, 8'h0F, 10'd1023, 9'd511, 8'hFF);
        push_word(epdu_pkg::OP_PIXEL, 8'h10, 10'd0, 9'd0, 8'h00);
        push_word(epdu_pkg::OP_PIXEL, 8'h10, 10'd1, 9'd0, 8'h00);
        push_word(epdu_pkg::OP_PIXEL, 8'hFF, 10'd1023, 9'd0, 8'h00);
        push_word(epdu_pkg::OP_PIXEL, 8'hF0, 10'd0, 9'd511, 8'h00);
        push_word(epdu_pkg::OP_PIXEL, 8'h55, 10'd2, 9'd3, 8'h00);
        push_word(epdu_pkg::OP_PIXEL, 8'hA5, 10'd1023, 9'd511, 8'h00);
        push_word(epdu_pkg::OP_PIXEL, 8'hA5, 10'd0, 9'd1, 8'h00);
        push_word(epdu_pkg::OP_READ, 8'h00, 10'd0, 9'd0, 8'hF5);
        push_word(epdu_pkg::OP_READ, 8'hFF, 10'd1023, 9'd511, 8'h10);
        push_word(epdu_pkg::OP_READ, 8'h00, 10'd0, 9'd0, 8'h00);
        push_word(epdu_pkg::OP_READ, 8'h00, 10'd0, 9'd0, 8'hFF);
        push_word(OP_UNUSED, 8'hFF, 10'd1023, 9'd511, 8'hF5);
        push_word(epdu_pkg::OP_CLEAR, 8'hFF, 10'd1, 9'd0, 8'hF5);
        push_word(epdu_pkg::OP_READ, 8'h00, 10'd0, 9'd0, 8'hF5);
        push_word(epdu_pkg::OP_PIXEL, 8'h81, 10'd0, 9'd0, 8'h00);
        push_word(epdu_pkg::OP_READ, 8'h00, 10'd0, 9'd0, 8'h91);
        push_word(OP_UNUSED, 8'h00, 10'd0, 9'd0, 8'h00);

        // Random words in undither mode with moderate stalls.
        stall_pct = 25;
        for (i = 0; i < 200; i++) push_random_word();
        wait_drained();

        // Plain dither mode: the histogram is neither counted nor visible.
        write_mode(1'b0);
        push_word(epdu_pkg::OP_PIXEL, 8'hA5, 10'd1, 9'd0, 8'h00);
        push_word(epdu_pkg::OP_PIXEL, 8'h0F, 10'd0, 9'd0, 8'h00);
        push_word(epdu_pkg::OP_READ, 8'h00, 10'd0, 9'd0, 8'h91);
        push_word(epdu_pkg::OP_CLEAR, 8'h00, 10'd0, 9'd0, 8'h00);
        push_word(epdu_pkg::OP_PIXEL, 8'hFF, 10'd0, 9'd0, 8'h00);
        push_word(OP_UNUSED, 8'hFF, 10'd1023, 9'd511, 8'hFF);
        stall_pct = 40;
        refill_hot_colors();
        for (i = 0; i < 150; i++) push_random_word();
        wait_drained();

        // Back to undither mode with heavy stalls.
        write_mode(1'b1);
        stall_pct = 50;
        refill_hot_colors();
        for (i = 0; i < 150; i++) push_random_word();
        wait_drained();

        // Back-to-back hits on one counter, read in between.
        stall_pct = 0;
        push_word(epdu_pkg::OP_CLEAR, 8'h00, 10'd0, 9'd0, 8'h00);
        for (i = 0; i < HitRun; i++)
            push_word(epdu_pkg::OP_PIXEL, 8'h3C, 10'($urandom_range(1023)),
                      9'($urandom_range(511)), 8'h00);
        push_word(epdu_pkg::OP_READ, 8'h00, 10'd0, 9'd0, 8'hFC);
        push_word(epdu_pkg::OP_PIXEL, 8'h3C, 10'd0, 9'd0, 8'h00);
        push_word(epdu_pkg::OP_READ, 8'h00, 10'd0, 9'd0, 8'hFC);
        push_word(epdu_pkg::OP_PIXEL, 8'h3C, 10'd1, 9'd0, 8'h00);
        push_word(epdu_pkg::OP_READ, 8'h00, 10'd0, 9'd0, 8'hFC);
        wait_drained();

        // Final stretch at full rate.
        refill_hot_colors();
        for (i = 0; i < 80; i++) push_random_word();
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (err_count == 0 && awaited_results.size() == 0) begin
            $display("ega_pixel_dither_undither test passed");
        end else begin
            $display("ega_pixel_dither_undither test failed");
        end
        $finish;
    end

endmodule
